// File: design/wcc_pkg.sv
// Shared types and constants of the windowed cross-correlator.
package wcc_pkg;

   localparam int PORT_SAMPLE_BITS = 16;
   localparam int CFG_BITS         = 7;
   localparam int LAG_BITS         = 6;
   localparam int CORR_BITS        = 26;
   localparam int ACC_BITS         = 32;
   localparam int MUL_BITS         = 33;
   localparam int PROD_BITS        = 64;

   localparam logic [CFG_BITS-1:0] LAG_COUNT_RESET = 7'd64;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MAC   = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_RECIP = 6'b001000,
      ST_QMUL  = 6'b010000,
      ST_FIX   = 6'b100000
   } state_type;

endpackage

// File: design/windowed_cross_correlator_unit.sv
// Windowed cross-correlator: sample windows, shared multiplier and lag sequencer.
//
// A word is accepted on a rising edge with start high and busy low. Every word
// pushes its left and right samples into two sliding windows of WINDOW entries.
// When evaluate is set, the block then works out one correlation value per lag,
// from lag 0 up to lag_count - 1, with lag_count clamped to WINDOW.
// Lag k runs WINDOW - k multiply-accumulates, one per cycle, on the single
// shared multiplier, then drains the pipeline, and then the same multiplier
// divides the sum by WINDOW through a reciprocal. A word without evaluate
// leaves the block idle and ready for the next word. Busy stays high until
// the last value is issued.
// Each value is shown on the rsp_ ports for one cycle with rsp_valid high;
// rsp_last marks the final lag. The receiver cannot stall the block.
// The csr_ channel writes lag_count; it is always ready and should be used
// only while busy is low.
// Synchronous reset clears the windows to zero through per-entry valid bits,
// sets the write position to zero and lag_count to 64; no clearing pass runs.
module windowed_cross_correlator_unit #(
   parameter int WINDOW      = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic signed [wcc_pkg::PORT_SAMPLE_BITS-1:0]   req_left_sample,
   input  logic signed [wcc_pkg::PORT_SAMPLE_BITS-1:0]   req_right_sample,
   input  logic                                          req_evaluate,
   output logic                                          rsp_valid,
   output logic        [wcc_pkg::LAG_BITS-1:0]           rsp_lag,
   output logic signed [wcc_pkg::CORR_BITS-1:0]          rsp_corr_value,
   output logic                                          rsp_last,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic        [wcc_pkg::CFG_BITS-1:0]           csr_wdata
);
   import wcc_pkg::*;

   localparam int SB = (SAMPLE_BITS > PORT_SAMPLE_BITS) ? PORT_SAMPLE_BITS : SAMPLE_BITS;
   localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [AW:0]         WIN_CNT  = (AW + 1)'(WINDOW);
   localparam logic [AW:0]         WIN_LAST = (AW + 1)'(WINDOW - 1);
   localparam logic [CFG_BITS-1:0] WIN_CFG  = CFG_BITS'(WINDOW);
   localparam logic [MUL_BITS-1:0] WIN_MUL  = MUL_BITS'(WINDOW);
   localparam logic [MUL_BITS-1:0] RECIP    = MUL_BITS'((64'd1 << 32) / WINDOW);

   state_type              state_ff, state_in;
   logic [CFG_BITS-1:0]    lag_count_ff, lag_count_in;
   logic [AW-1:0]          wp_ff, wp_in;
   logic [WINDOW-1:0]      valid_ff, valid_in;
   logic [AW:0]            lags_ff, lags_in;
   logic [AW-1:0]          k_ff, k_in;
   logic [AW-1:0]          n_ff, n_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic                   prod_vld_ff, prod_vld_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [MUL_BITS-1:0]    mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [31:0]            q0_ff, q0_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LAG_BITS-1:0]    rsp_lag_ff, rsp_lag_in;
   logic [CORR_BITS-1:0]   rsp_corr_ff, rsp_corr_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [SB-1:0]          left_mem [WINDOW];
   logic [SB-1:0]          right_mem [WINDOW];
   logic [SB-1:0]          rd_r_ff, rd_l_ff;
   logic                   vr_ff, vl_ff;

   logic                   accept;
   logic                   issue;
   logic                   last_issue;
   logic                   last_lag;
   logic [AW-1:0]          ra_r, ra_l;
   logic [AW:0]            lags_req;
   logic signed [MUL_BITS-1:0]   mul_a, mul_b;
   logic signed [2*MUL_BITS-1:0] mul_p;
   logic [MUL_BITS-1:0]    acc_ext, remain, q_ext, q_signed;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW:0] ofs);
      logic [AW+1:0] sum;
      sum = {1'b0, 1'b0, base} + {1'b0, ofs};
      if (sum >= (AW + 2)'(WINDOW)) begin
         sum = sum - (AW + 2)'(WINDOW);
      end
      return sum[AW-1:0];
   endfunction

   assign accept     = start && (state_ff == ST_IDLE);
   assign issue      = (state_ff == ST_MAC);
   assign last_issue = (({1'b0, n_ff} + {1'b0, k_ff}) == WIN_LAST);
   assign last_lag   = (({1'b0, k_ff} + (AW + 1)'(1)) == lags_ff);
   assign ra_r       = phys(wp_ff, {1'b0, n_ff});
   assign ra_l       = phys(wp_ff, {1'b0, n_ff} + {1'b0, k_ff});
   assign lags_req   = (lag_count_ff > WIN_CFG) ? WIN_CNT : lag_count_ff[AW:0];
   assign acc_ext    = {acc_ff[ACC_BITS-1], acc_ff};
   assign remain     = mag_ff - prod_ff[MUL_BITS-1:0];
   assign q_ext      = {1'b0, q0_ff} + ((remain >= WIN_MUL) ? MUL_BITS'(1) : MUL_BITS'(0));
   assign q_signed   = neg_ff ? (~q_ext + MUL_BITS'(1)) : q_ext;

   always_comb begin
      case (state_ff)
         ST_RECIP: begin
            mul_a = mag_in;
            mul_b = RECIP;
         end
         ST_QMUL: begin
            mul_a = {1'b0, prod_ff[63:32]};
            mul_b = WIN_MUL;
         end
         default: begin
            mul_a = vr_ff ? {{(MUL_BITS - SB){rd_r_ff[SB-1]}}, rd_r_ff} : '0;
            mul_b = vl_ff ? {{(MUL_BITS - SB){rd_l_ff[SB-1]}}, rd_l_ff} : '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      lag_count_in = lag_count_ff;
      wp_in        = wp_ff;
      valid_in     = valid_ff;
      lags_in      = lags_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      rd_vld_in    = issue;
      prod_vld_in  = rd_vld_ff;
      acc_in       = acc_ff;
      mag_in       = acc_ff[ACC_BITS-1] ? (~acc_ext + MUL_BITS'(1)) : acc_ext;
      neg_in       = neg_ff;
      q0_in        = q0_ff;
      rsp_valid_in = 1'b0;
      rsp_lag_in   = rsp_lag_ff;
      rsp_corr_in  = rsp_corr_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         lag_count_in = csr_wdata;
      end
      if (prod_vld_ff) begin
         acc_in = acc_ff + prod_ff[ACC_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in[wp_ff] = 1'b1;
               wp_in = (wp_ff == WIN_LAST[AW-1:0]) ? '0 : wp_ff + AW'(1);
               lags_in = lags_req;
               k_in = '0;
               n_in = '0;
               acc_in = '0;
               if (req_evaluate && (lags_req != '0)) begin
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            n_in = n_ff + AW'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            neg_in = acc_ff[ACC_BITS-1];
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            q0_in = prod_ff[63:32];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            rsp_valid_in = 1'b1;
            rsp_lag_in   = LAG_BITS'(k_ff);
            rsp_corr_in  = q_signed[CORR_BITS-1:0];
            rsp_last_in  = last_lag;
            n_in   = '0;
            acc_in = '0;
            if (last_lag) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + AW'(1);
               state_in = ST_MAC;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lag_count_ff <= LAG_COUNT_RESET;
         wp_ff        <= '0;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lag_count_ff <= lag_count_in;
         wp_ff        <= wp_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lags_ff     <= lags_in;
      k_ff        <= k_in;
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      q0_ff       <= q0_in;
      prod_ff     <= mul_p[PROD_BITS-1:0];
      rsp_lag_ff  <= rsp_lag_in;
      rsp_corr_ff <= rsp_corr_in;
      rsp_last_ff <= rsp_last_in;
      vr_ff       <= valid_ff[ra_r];
      vl_ff       <= valid_ff[ra_l];
   end

   always_ff @(posedge clock) begin
      rd_r_ff <= right_mem[ra_r];
      rd_l_ff <= left_mem[ra_l];
      if (accept) begin
         left_mem[wp_ff]  <= req_left_sample[SB-1:0];
         right_mem[wp_ff] <= req_right_sample[SB-1:0];
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lag        = rsp_lag_ff;
   assign rsp_corr_value = rsp_corr_ff;
   assign rsp_last       = rsp_last_ff;

   // A result word only follows the correction step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FIX))
      else $error("result word without a correction step");

   // The final lag of an evaluation returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("block still busy after the final lag");

   // An evaluation with a nonzero lag count keeps the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_evaluate && (lags_req != '0)) |=> busy)
      else $error("evaluation did not start");

   // Products are only in flight while the shared multiplier does accumulation.
   assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff == ST_MAC || state_ff == ST_DRAIN))
      else $error("product in flight outside accumulation");

endmodule

// File: dv/windowed_cross_correlator_unit_tb.sv
// Self-checking testbench of the windowed cross-correlator: directed table, random phases.
`timescale 1ns / 100ps

module windowed_cross_correlator_unit_tb;
   import wcc_pkg::*;

   localparam int WIN      = 64;
   localparam int NO_WRITE = -1;

   typedef struct {
      logic [LAG_BITS-1:0]         lag;
      logic signed [CORR_BITS-1:0] corr;
      logic                        last;
   } corr_word_type;

   typedef struct packed {
      int lags;
      int left;
      int right;
      bit evaluate;
      bit typed;
      int typed_lag0;
   } dir_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic signed [PORT_SAMPLE_BITS-1:0]  req_left_sample;
   logic signed [PORT_SAMPLE_BITS-1:0]  req_right_sample;
   logic                                req_evaluate;
   logic                                rsp_valid;
   logic        [LAG_BITS-1:0]          rsp_lag;
   logic signed [CORR_BITS-1:0]         rsp_corr_value;
   logic                                rsp_last;
   logic                                csr_valid;
   logic                                csr_ready;
   logic        [CFG_BITS-1:0]          csr_wdata;

   corr_word_type pending_corr [$];
   int            mismatches = 0;

   logic signed [PORT_SAMPLE_BITS-1:0] left_hist  [WIN];
   logic signed [PORT_SAMPLE_BITS-1:0] right_hist [WIN];
   int                                 wr_ptr;
   int                                 lag_setting;

   dir_row_type directed_words [0:11] = '{
      '{NO_WRITE, -32768, -32768, 1'b1, 1'b1, 16777216},
      '{NO_WRITE, -32768, -32768, 1'b0, 1'b0, 0},
      '{NO_WRITE, -32768, -32768, 1'b1, 1'b1, -16777216},
      '{1,         32767,  32767, 1'b1, 1'b0, 0},
      '{0,             1,     -1, 1'b1, 1'b0, 0},
      '{NO_WRITE,      0,      0, 1'b1, 1'b0, 0},
      '{127,       32767, -32768, 1'b1, 1'b0, 0},
      '{65,        21845, -21846, 1'b1, 1'b0, 0},
      '{2,            -1,     -1, 1'b0, 1'b0, 0},
      '{NO_WRITE,  21845,  21845, 1'b1, 1'b0, 0},
      '{63,          100,   -100, 1'b1, 1'b0, 0},
      '{64,       -21846,  21845, 1'b1, 1'b0, 0}
   };

   windowed_cross_correlator_unit #(
      .WINDOW      (WIN),
      .SAMPLE_BITS (PORT_SAMPLE_BITS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_evaluate     (req_evaluate),
      .rsp_valid        (rsp_valid),
      .rsp_lag          (rsp_lag),
      .rsp_corr_value   (rsp_corr_value),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

   // Pushes the pair into the windows and, with evaluate set, queues one correlation word per lag.
   task automatic push_pair_and_correlate(input int l, input int r, input bit eval,
                                          input bit typed, input int typed_lag0);
      int            lags;
      int            pr;
      int            q;
      bit [31:0]     acc;
      corr_word_type w;
      left_hist[wr_ptr]  = PORT_SAMPLE_BITS'(l);
      right_hist[wr_ptr] = PORT_SAMPLE_BITS'(r);
      wr_ptr = (wr_ptr + 1) % WIN;
      if (!eval) return;
      lags = (lag_setting > WIN) ? WIN : lag_setting;
      for (int k = 0; k < lags; k++) begin
         acc = '0;
         for (int n = 0; n + k < WIN; n++) begin
            pr  = int'(right_hist[(wr_ptr + n) % WIN]) *
                  int'(left_hist[(wr_ptr + n + k) % WIN]);
            acc = acc + pr;
         end
         q      = $signed(acc) / WIN;
         w.lag  = LAG_BITS'(k);
         w.corr = (typed && k == 0) ? CORR_BITS'(typed_lag0) : q[CORR_BITS-1:0];
         w.last = (k + 1 == lags);
         pending_corr.insert(pending_corr.size(), w);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return int'($urandom_range(0, 15)) - 8;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   task automatic send_word(input int gap, input int l, input int r, input bit eval,
                            input bit typed, input int typed_lag0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_left_sample  <= PORT_SAMPLE_BITS'(l);
      req_right_sample <= PORT_SAMPLE_BITS'(r);
      req_evaluate     <= eval;
      do @(posedge clock); while (busy);
      push_pair_and_correlate(l, r, eval, typed, typed_lag0);
   endtask

   task automatic set_lag_count(input int value);
      start <= 1'b0;
      while (pending_corr.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= CFG_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      lag_setting = value;
   endtask

   function automatic int pick_lag_count();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 127;
         2: return 64;
         3: return 1;
         4: return 65;
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   always @(posedge clock) begin : check_results
      corr_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_corr.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: lag %0d corr %0d last %0b",
                        rsp_lag, rsp_corr_value, rsp_last);
         end else begin
            want = pending_corr.pop_front();
            if (rsp_lag !== want.lag || rsp_corr_value !== want.corr ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected lag %0d corr %0d last %0b,",
                           want.lag, want.corr, want.last,
                           " got lag %0d corr %0d last %0b",
                           rsp_lag, rsp_corr_value, rsp_last);
            end
         end
      end
   end

   initial begin
      bit quiet;
      reset            = 1'b1;
      start            = 1'b0;
      req_left_sample  = '0;
      req_right_sample = '0;
      req_evaluate     = 1'b0;
      csr_valid        = 1'b0;
      csr_wdata        = '0;
      wr_ptr           = 0;
      lag_setting      = int'(LAG_COUNT_RESET);
      foreach (left_hist[i]) begin
         left_hist[i]  = '0;
         right_hist[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i]) begin
         if (directed_words[i].lags != NO_WRITE)
            set_lag_count(directed_words[i].lags);
         send_word(pick_gap(), directed_words[i].left, directed_words[i].right,
                   directed_words[i].evaluate, directed_words[i].typed,
                   directed_words[i].typed_lag0);
      end

      for (int phase = 0; phase < 9; phase++) begin
         set_lag_count(pick_lag_count());
         quiet = ($urandom_range(0, 3) == 0);
         repeat (21)
            send_word(quiet ? 0 : pick_gap(), rand_sample(), rand_sample(),
                      $urandom_range(0, 2) == 0, 1'b0, 0);
      end

      start <= 1'b0;
      while (pending_corr.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: sim.f
design/wcc_pkg.sv
design/windowed_cross_correlator_unit.sv
dv/windowed_cross_correlator_unit_tb.sv
